@@ rtl/pwb_pkg.sv @@
// ----------------------------------------------------------------------------
// pwb_pkg
// Types, register indexes, wipe mode codes and constants shared by the wipe
// blend pipeline.
// ----------------------------------------------------------------------------
package pwb_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIPE_MODE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE          = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_HEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISSOLVE_SEED = 3'd4;

   localparam logic [6:0] MODE_SOFT_DOWN   = 7'd2;
   localparam logic [6:0] MODE_SOFT_UP     = 7'd3;
   localparam logic [6:0] MODE_SOFT_RIGHT  = 7'd4;
   localparam logic [6:0] MODE_SOFT_LEFT   = 7'd5;
   localparam logic [6:0] MODE_SPLIT_OPEN  = 7'd6;
   localparam logic [6:0] MODE_SPLIT_CLOSE = 7'd7;
   localparam logic [6:0] MODE_DIAMOND_64  = 7'd8;
   localparam logic [6:0] MODE_DIAMOND_32  = 7'd9;
   localparam logic [6:0] MODE_DIAMOND_16  = 7'd10;
   localparam logic [6:0] MODE_DISSOLVE    = 7'd21;

   localparam logic [8:0]  WEIGHT_FULL   = 9'd256;
   localparam logic [8:0]  DIAMOND_FLOOR = 9'd16;
   localparam int          SOFT_OFFSET   = 255;
   localparam int          SPLIT_OFFSET  = 127;
   localparam int          SPLIT_HALF    = 64;
   localparam logic [5:0]  DIAMOND_MASK  = 6'h3f;
   localparam logic [5:0]  DIAMOND_HALF  = 6'd32;
   localparam logic [6:0]  DIAMOND_SPAN  = 7'd96;
   localparam logic [31:0] HASH_MUL_A    = 32'h9e3779b9;
   localparam logic [31:0] HASH_MUL_B    = 32'h7feb352d;

   typedef enum logic [2:0] {
      CLS_FADE,
      CLS_SOFT_LEAD,
      CLS_SOFT_TRAIL,
      CLS_SPLIT_OPEN,
      CLS_SPLIT_CLOSE,
      CLS_DIAMOND,
      CLS_DISSOLVE
   } pwb_class_type;

   typedef struct packed {
      logic [6:0]  wipe_mode;
      logic [8:0]  rate;
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [31:0] dissolve_seed;
   } pwb_cfg_type;

   localparam pwb_cfg_type CFG_RESET = '{
      wipe_mode:     7'd0,
      rate:          9'd0,
      frame_width:   12'd800,
      frame_height:  12'd600,
      dissolve_seed: 32'd0
   };

   typedef struct packed {
      logic [7:0] old_red;
      logic [7:0] old_green;
      logic [7:0] old_blue;
      logic [7:0] new_red;
      logic [7:0] new_green;
      logic [7:0] new_blue;
   } pwb_pix_type;

endpackage

@@ rtl/pwb_csr_if.sv @@
// ----------------------------------------------------------------------------
// pwb_csr_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface pwb_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pwb_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [pwb_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/pwb_req_if.sv @@
// ----------------------------------------------------------------------------
// pwb_req_if
// Pixel request channel: position plus the old and new frame pixel.
// ----------------------------------------------------------------------------
interface pwb_req_if #(parameter int COORD_WIDTH = 12);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] pixel_x;
   logic [COORD_WIDTH-1:0] pixel_y;
   logic [7:0]             old_red;
   logic [7:0]             old_green;
   logic [7:0]             old_blue;
   logic [7:0]             new_red;
   logic [7:0]             new_green;
   logic [7:0]             new_blue;

   modport source (
      output valid, output pixel_x, output pixel_y,
      output old_red, output old_green, output old_blue,
      output new_red, output new_green, output new_blue,
      input  ready
   );
   modport sink (
      input  valid, input pixel_x, input pixel_y,
      input  old_red, input old_green, input old_blue,
      input  new_red, input new_green, input new_blue,
      output ready
   );
endinterface

@@ rtl/pwb_rsp_if.sv @@
// ----------------------------------------------------------------------------
// pwb_rsp_if
// Blended pixel response channel: RGB and the weight that was applied.
// ----------------------------------------------------------------------------
interface pwb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [8:0] mix_weight;

   modport source (
      output valid, output out_red, output out_green, output out_blue,
      output mix_weight, input ready
   );
   modport sink (
      input  valid, input out_red, input out_green, input out_blue,
      input  mix_weight, output ready
   );
endinterface

@@ rtl/pwb_weight.sv @@
// ----------------------------------------------------------------------------
// pwb_weight
// Four-stage weight pipeline: edge and hash products, offsets and hash mix,
// wipe ramp and second hash product, final weight select.
// ----------------------------------------------------------------------------
module pwb_weight #(
   parameter int COORD_WIDTH = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pwb_pkg::pwb_cfg_type   cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [COORD_WIDTH-1:0] in_x,
   input  logic [COORD_WIDTH-1:0] in_y,
   input  pwb_pkg::pwb_pix_type   in_pix,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [8:0]             out_weight,
   output pwb_pkg::pwb_pix_type   out_pix
);

   localparam int TW = ((COORD_WIDTH > 13) ? COORD_WIDTH : 13) + 2;
   localparam int YW = COORD_WIDTH + 12;

   logic adv1, adv2, adv3, adv4;
   logic [10:0] hw;

   // stage 1 next values
   logic [8:0]                r_in;
   pwb_pkg::pwb_class_type    cls_in;
   logic                      use_y_in;
   logic                      rise_in;
   logic [12:0]               base;
   logic [8:0]                factor;
   logic [21:0]               edge_prod;
   logic [12:0]               edge_in;
   logic signed [TW-1:0]      xd;
   logic signed [TW-1:0]      a_in;
   logic [YW-1:0]             yw_in;
   logic [31:0]               seedk_in;
   logic [1:0]                sh;
   logic [5:0]                dmask;
   logic [5:0]                dhalf;
   logic [6:0]                dspan;
   logic [5:0]                xm;
   logic [5:0]                ym;
   logic signed [6:0]         dx;
   logic signed [6:0]         dy;
   logic [5:0]                dax_in;
   logic [5:0]                day_in;
   logic [15:0]               ext_prod;
   logic signed [7:0]         ext_in;
   logic [17:0]               sq_prod;
   logic [8:0]                dw_in;

   // stage 1 registers
   logic                      s1_valid_ff;
   logic [COORD_WIDTH-1:0]    s1_x_ff;
   logic [8:0]                s1_r_ff;
   pwb_pkg::pwb_class_type    s1_cls_ff;
   logic [12:0]               s1_edge_ff;
   logic signed [TW-1:0]      s1_a_ff;
   logic [YW-1:0]             s1_yw_ff;
   logic [31:0]               s1_seedk_ff;
   logic [5:0]                s1_dax_ff;
   logic [5:0]                s1_day_ff;
   logic signed [7:0]         s1_ext_ff;
   logic [8:0]                s1_dw_ff;
   pwb_pkg::pwb_pix_type      s1_pix_ff;

   // stage 2
   logic signed [TW-1:0]      edge_s;
   logic signed [TW-1:0]      hw_s;
   logic signed [TW-1:0]      b_in;
   logic [31:0]               hash_v0;
   logic [31:0]               hash_v1;
   logic [22:0]               hash_in;
   logic signed [8:0]         drhs;
   logic                      inside_in;

   logic                      s2_valid_ff;
   logic [8:0]                s2_r_ff;
   pwb_pkg::pwb_class_type    s2_cls_ff;
   logic signed [TW-1:0]      s2_a_ff;
   logic signed [TW-1:0]      s2_b_ff;
   logic [22:0]               s2_hash_ff;
   logic                      s2_inside_ff;
   logic [8:0]                s2_dw_ff;
   pwb_pkg::pwb_pix_type      s2_pix_ff;

   // stage 3
   logic signed [TW-1:0]      t;
   logic                      neg;
   logic [8:0]                wipe_in;
   logic [22:0]               p_in;
   logic [8:0]                dsel_in;

   logic                      s3_valid_ff;
   logic [8:0]                s3_r_ff;
   pwb_pkg::pwb_class_type    s3_cls_ff;
   logic [8:0]                s3_wipe_ff;
   logic [22:0]               s3_p_ff;
   logic [8:0]                s3_dsel_ff;
   pwb_pkg::pwb_pix_type      s3_pix_ff;

   // stage 4
   logic [7:0]                hbyte;
   logic [8:0]                w_in;

   logic                      s4_valid_ff;
   logic [8:0]                s4_w_ff;
   pwb_pkg::pwb_pix_type      s4_pix_ff;

   assign adv4     = !s4_valid_ff || out_ready;
   assign adv3     = !s3_valid_ff || adv4;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   assign hw = cfg.frame_width[11:1];

   // ---------------- stage 1 ----------------
   always_comb begin
      r_in     = (cfg.rate > pwb_pkg::WEIGHT_FULL) ? pwb_pkg::WEIGHT_FULL : cfg.rate;
      cls_in   = pwb_pkg::CLS_FADE;
      use_y_in = 1'b0;
      rise_in  = 1'b0;
      unique case (cfg.wipe_mode) inside
         pwb_pkg::MODE_SOFT_DOWN: begin
            cls_in   = pwb_pkg::CLS_SOFT_LEAD;
            use_y_in = 1'b1;
         end
         pwb_pkg::MODE_SOFT_UP: begin
            cls_in   = pwb_pkg::CLS_SOFT_TRAIL;
            use_y_in = 1'b1;
            rise_in  = 1'b1;
         end
         pwb_pkg::MODE_SOFT_RIGHT: begin
            cls_in = pwb_pkg::CLS_SOFT_LEAD;
         end
         pwb_pkg::MODE_SOFT_LEFT: begin
            cls_in  = pwb_pkg::CLS_SOFT_TRAIL;
            rise_in = 1'b1;
         end
         pwb_pkg::MODE_SPLIT_OPEN: begin
            cls_in = pwb_pkg::CLS_SPLIT_OPEN;
         end
         pwb_pkg::MODE_SPLIT_CLOSE: begin
            cls_in  = pwb_pkg::CLS_SPLIT_CLOSE;
            rise_in = 1'b1;
         end
         pwb_pkg::MODE_DIAMOND_64, pwb_pkg::MODE_DIAMOND_32,
         pwb_pkg::MODE_DIAMOND_16: begin
            cls_in = pwb_pkg::CLS_DIAMOND;
         end
         pwb_pkg::MODE_DISSOLVE: begin
            cls_in = pwb_pkg::CLS_DISSOLVE;
         end
         default: begin
            cls_in = pwb_pkg::CLS_FADE;
         end
      endcase

      if (cls_in == pwb_pkg::CLS_SPLIT_OPEN || cls_in == pwb_pkg::CLS_SPLIT_CLOSE) begin
         base = {2'b00, hw} + 13'(pwb_pkg::SPLIT_OFFSET);
      end else if (use_y_in) begin
         base = {1'b0, cfg.frame_height} + 13'(pwb_pkg::SOFT_OFFSET);
      end else begin
         base = {1'b0, cfg.frame_width} + 13'(pwb_pkg::SOFT_OFFSET);
      end
      factor    = rise_in ? r_in : (pwb_pkg::WEIGHT_FULL - r_in);
      edge_prod = 22'(base) * 22'(factor);
      edge_in   = edge_prod[20:8];

      xd = $signed({{(TW-COORD_WIDTH){1'b0}}, in_x}) - $signed({{(TW-11){1'b0}}, hw});
      if (cls_in == pwb_pkg::CLS_SPLIT_OPEN || cls_in == pwb_pkg::CLS_SPLIT_CLOSE) begin
         a_in = (xd < 0) ? -xd : xd;
      end else if (use_y_in) begin
         a_in = $signed({{(TW-COORD_WIDTH){1'b0}}, in_y});
      end else begin
         a_in = $signed({{(TW-COORD_WIDTH){1'b0}}, in_x});
      end

      yw_in    = YW'(in_y) * YW'(cfg.frame_width);
      seedk_in = cfg.dissolve_seed * pwb_pkg::HASH_MUL_A;

      sh       = 2'(cfg.wipe_mode - pwb_pkg::MODE_DIAMOND_64);
      dmask    = pwb_pkg::DIAMOND_MASK >> sh;
      dhalf    = pwb_pkg::DIAMOND_HALF >> sh;
      dspan    = pwb_pkg::DIAMOND_SPAN >> sh;
      xm       = in_x[5:0] & dmask;
      ym       = in_y[5:0] & dmask;
      dx       = $signed({1'b0, xm}) - $signed({1'b0, dhalf});
      dy       = $signed({1'b0, ym}) - $signed({1'b0, dhalf});
      dax_in   = 6'((dx < 0) ? -dx : dx);
      day_in   = 6'((dy < 0) ? -dy : dy);
      ext_prod = 16'(dspan) * 16'(r_in);
      ext_in   = $signed({1'b0, ext_prod[14:8]}) - $signed({2'b00, dhalf});
      sq_prod  = 18'(r_in) * 18'(r_in);
      dw_in    = pwb_pkg::DIAMOND_FLOOR + sq_prod[17:9];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_x_ff     <= in_x;
         s1_r_ff     <= r_in;
         s1_cls_ff   <= cls_in;
         s1_edge_ff  <= edge_in;
         s1_a_ff     <= a_in;
         s1_yw_ff    <= yw_in;
         s1_seedk_ff <= seedk_in;
         s1_dax_ff   <= dax_in;
         s1_day_ff   <= day_in;
         s1_ext_ff   <= ext_in;
         s1_dw_ff    <= dw_in;
         s1_pix_ff   <= in_pix;
      end
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      edge_s = $signed({{(TW-13){1'b0}}, s1_edge_ff});
      hw_s   = $signed({{(TW-11){1'b0}}, hw});
      case (s1_cls_ff)
         pwb_pkg::CLS_SOFT_LEAD:   b_in = TW'(pwb_pkg::SOFT_OFFSET) - edge_s;
         pwb_pkg::CLS_SOFT_TRAIL:  b_in = edge_s;
         pwb_pkg::CLS_SPLIT_OPEN:  b_in = hw_s - edge_s + TW'(pwb_pkg::SPLIT_OFFSET);
         pwb_pkg::CLS_SPLIT_CLOSE: b_in = edge_s - hw_s;
         default:                  b_in = '0;
      endcase

      hash_v0   = 32'(s1_x_ff) + 32'(s1_yw_ff) + s1_seedk_ff;
      hash_v1   = hash_v0 ^ (hash_v0 >> 16);
      hash_in   = hash_v1[22:0];

      drhs      = $signed({3'b000, s1_day_ff}) + $signed({s1_ext_ff[7], s1_ext_ff});
      inside_in = $signed({3'b000, s1_dax_ff}) < drhs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_r_ff      <= s1_r_ff;
         s2_cls_ff    <= s1_cls_ff;
         s2_a_ff      <= s1_a_ff;
         s2_b_ff      <= b_in;
         s2_hash_ff   <= hash_in;
         s2_inside_ff <= inside_in;
         s2_dw_ff     <= s1_dw_ff;
         s2_pix_ff    <= s1_pix_ff;
      end
   end

   // ---------------- stage 3 ----------------
   always_comb begin
      neg = (s2_cls_ff == pwb_pkg::CLS_SOFT_TRAIL) || (s2_cls_ff == pwb_pkg::CLS_SPLIT_OPEN);
      t   = neg ? (s2_b_ff - s2_a_ff) : (s2_b_ff + s2_a_ff);
      case (s2_cls_ff) inside
         pwb_pkg::CLS_SOFT_LEAD, pwb_pkg::CLS_SOFT_TRAIL: begin
            if (t <= 0) begin
               wipe_in = 9'd0;
            end else if (t >= pwb_pkg::SOFT_OFFSET) begin
               wipe_in = pwb_pkg::WEIGHT_FULL;
            end else begin
               wipe_in = 9'(t);
            end
         end
         default: begin
            if (t <= 0) begin
               wipe_in = 9'd0;
            end else if (t >= pwb_pkg::SPLIT_OFFSET) begin
               wipe_in = pwb_pkg::WEIGHT_FULL;
            end else begin
               wipe_in = {t[7:0], 1'b0} + {8'd0, (t >= pwb_pkg::SPLIT_HALF)};
            end
         end
      endcase

      p_in    = s2_hash_ff * pwb_pkg::HASH_MUL_B[22:0];
      dsel_in = s2_inside_ff ? s2_dw_ff : 9'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_r_ff    <= s2_r_ff;
         s3_cls_ff  <= s2_cls_ff;
         s3_wipe_ff <= wipe_in;
         s3_p_ff    <= p_in;
         s3_dsel_ff <= dsel_in;
         s3_pix_ff  <= s2_pix_ff;
      end
   end

   // ---------------- stage 4 ----------------
   always_comb begin
      hbyte = s3_p_ff[7:0] ^ s3_p_ff[22:15];
      case (s3_cls_ff) inside
         pwb_pkg::CLS_SOFT_LEAD, pwb_pkg::CLS_SOFT_TRAIL,
         pwb_pkg::CLS_SPLIT_OPEN, pwb_pkg::CLS_SPLIT_CLOSE: w_in = s3_wipe_ff;
         pwb_pkg::CLS_DIAMOND:  w_in = s3_dsel_ff;
         pwb_pkg::CLS_DISSOLVE: w_in = ({1'b0, hbyte} < s3_r_ff) ? pwb_pkg::WEIGHT_FULL : 9'd0;
         default:               w_in = s3_r_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_w_ff   <= w_in;
         s4_pix_ff <= s3_pix_ff;
      end
   end

   assign out_valid  = s4_valid_ff;
   assign out_weight = s4_w_ff;
   assign out_pix    = s4_pix_ff;

endmodule

@@ rtl/pwb_blend.sv @@
// ----------------------------------------------------------------------------
// pwb_blend
// Two-stage RGB mixer: weighted products per channel, then sum and scale
// into the output register.
// ----------------------------------------------------------------------------
module pwb_blend (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [8:0]           in_weight,
   input  pwb_pkg::pwb_pix_type in_pix,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_red,
   output logic [7:0]           out_green,
   output logic [7:0]           out_blue,
   output logic [8:0]           out_weight
);

   logic             adv5, adv6;
   logic [8:0]       inv_w;
   logic [2:0][7:0]  old_ch;
   logic [2:0][7:0]  new_ch;
   logic [2:0][15:0] po_in;
   logic [2:0][15:0] pn_in;
   logic [2:0][16:0] sum;
   logic [2:0][7:0]  mix_in;

   logic             s5_valid_ff;
   logic [2:0][15:0] s5_po_ff;
   logic [2:0][15:0] s5_pn_ff;
   logic [8:0]       s5_w_ff;

   logic             s6_valid_ff;
   logic [2:0][7:0]  s6_mix_ff;
   logic [8:0]       s6_w_ff;

   assign adv6     = !s6_valid_ff || out_ready;
   assign adv5     = !s5_valid_ff || adv6;
   assign in_ready = adv5;

   always_comb begin
      inv_w     = pwb_pkg::WEIGHT_FULL - in_weight;
      old_ch[0] = in_pix.old_red;
      old_ch[1] = in_pix.old_green;
      old_ch[2] = in_pix.old_blue;
      new_ch[0] = in_pix.new_red;
      new_ch[1] = in_pix.new_green;
      new_ch[2] = in_pix.new_blue;
      for (int i = 0; i < 3; i++) begin
         po_in[i] = 16'(old_ch[i]) * 16'(inv_w);
         pn_in[i] = 16'(new_ch[i]) * 16'(in_weight);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv5) begin
         s5_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         s5_po_ff <= po_in;
         s5_pn_ff <= pn_in;
         s5_w_ff  <= in_weight;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i]    = {1'b0, s5_po_ff[i]} + {1'b0, s5_pn_ff[i]};
         mix_in[i] = sum[i][15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv6) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv6) begin
         s6_mix_ff <= mix_in;
         s6_w_ff   <= s5_w_ff;
      end
   end

   assign out_valid  = s6_valid_ff;
   assign out_red    = s6_mix_ff[0];
   assign out_green  = s6_mix_ff[1];
   assign out_blue   = s6_mix_ff[2];
   assign out_weight = s6_w_ff;

endmodule

@@ rtl/procedural_wipe_blend.sv @@
// ----------------------------------------------------------------------------
// procedural_wipe_blend
// Per-pixel transition blender: wipe-mode weight and old/new RGB mix.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, given no backpressure, and passes it through six
// registered stages: four stages form the weight (edge and
// hash products, offsets, ramp and second hash product, mode select) and two
// form the mix (channel products, sum and scale). Every stage holds its item
// while the next one is full, so a stall on the response side stops the
// pipeline without loss; ready follows the free slots through all six stages.
// Registers take effect for pixels transferred after the write and are meant
// to change only between frames, with the pipeline drained.
module procedural_wipe_blend #(
   parameter int COORD_WIDTH = 12
) (
   input logic        clock,
   input logic        reset,
   pwb_csr_if.sink    csr_if,
   pwb_req_if.sink    req_if,
   pwb_rsp_if.source  rsp_if
);

   pwb_pkg::pwb_cfg_type cfg_ff;
   pwb_pkg::pwb_cfg_type cfg_in;
   pwb_pkg::pwb_pix_type req_pix;
   pwb_pkg::pwb_pix_type mid_pix;
   logic                 mid_valid;
   logic                 mid_ready;
   logic [8:0]           mid_weight;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            pwb_pkg::CSR_WIPE_MODE:     cfg_in.wipe_mode     = csr_if.data[6:0];
            pwb_pkg::CSR_RATE:          cfg_in.rate          = csr_if.data[8:0];
            pwb_pkg::CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_if.data[11:0];
            pwb_pkg::CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_if.data[11:0];
            pwb_pkg::CSR_DISSOLVE_SEED: cfg_in.dissolve_seed = csr_if.data[31:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pwb_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_pix.old_red   = req_if.old_red;
   assign req_pix.old_green = req_if.old_green;
   assign req_pix.old_blue  = req_if.old_blue;
   assign req_pix.new_red   = req_if.new_red;
   assign req_pix.new_green = req_if.new_green;
   assign req_pix.new_blue  = req_if.new_blue;

   pwb_weight #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_weight (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_x       (req_if.pixel_x),
      .in_y       (req_if.pixel_y),
      .in_pix     (req_pix),
      .out_valid  (mid_valid),
      .out_ready  (mid_ready),
      .out_weight (mid_weight),
      .out_pix    (mid_pix)
   );

   pwb_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_weight  (mid_weight),
      .in_pix     (mid_pix),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_red    (rsp_if.out_red),
      .out_green  (rsp_if.out_green),
      .out_blue   (rsp_if.out_blue),
      .out_weight (rsp_if.mix_weight)
   );

endmodule

@@ tb/procedural_wipe_blend_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// procedural_wipe_blend_tb
// Self-checking bench for the wipe blend pipeline. Every pixel transfer is
// blended by a local copy of the weight and mix arithmetic. The expected blend
// is queued in order and compared field by field with each response transfer.
// A short directed pass visits every wipe mode with corner pixels. Random
// frames follow, each with its own register setting. The sender works in
// bursts and the receiver stalls on shifting patterns, including one long
// hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module procedural_wipe_blend_tb;

   localparam int COORD_WIDTH      = 12;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_ITEMS     = 800;
   localparam int DRAIN_CYCLES     = 12;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int LONG_HOLD_AT     = 300;

   localparam logic [6:0] MODE_FADE_TOP = 7'd127;
   localparam logic [6:0] WIPE_MODES [10] = '{
      pwb_pkg::MODE_SOFT_DOWN, pwb_pkg::MODE_SOFT_UP, pwb_pkg::MODE_SOFT_RIGHT,
      pwb_pkg::MODE_SOFT_LEFT, pwb_pkg::MODE_SPLIT_OPEN, pwb_pkg::MODE_SPLIT_CLOSE,
      pwb_pkg::MODE_DIAMOND_64, pwb_pkg::MODE_DIAMOND_32, pwb_pkg::MODE_DIAMOND_16,
      pwb_pkg::MODE_DISSOLVE
   };

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      pwb_pkg::pwb_pix_type   pix;
   } pixel_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [8:0] weight;
   } blend_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_HALF,
      READY_SPARSE
   } ready_pattern_type;

   logic clock;
   logic reset;

   pwb_csr_if                             csr_bus ();
   pwb_req_if #(.COORD_WIDTH(COORD_WIDTH)) req_bus ();
   pwb_rsp_if                             rsp_bus ();

   procedural_wipe_blend #(.COORD_WIDTH(COORD_WIDTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_bus),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   pwb_pkg::pwb_cfg_type shadow_cfg = pwb_pkg::CFG_RESET;
   pixel_item_type       pixel_queue [$];
   blend_type            blend_queue [$];
   pixel_item_type       offered;
   int                   error_count  = 0;
   int                   result_count = 0;
   int                   cycle_count  = 0;
   int                   burst_left   = 0;
   int                   gap_left     = 0;
   int                   pattern_left = 0;
   ready_pattern_type    ready_pattern = READY_ALWAYS;
   int                   hold_left    = 0;
   bit                   hold_done    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_weight(int v);
      return (v < 0) ? 0 : ((v > 256) ? 256 : v);
   endfunction

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [8:0] wipe_weight(pixel_item_type item);
      int        x, y, r, fw, fh, half, boundary;
      int        shift, tile_mask, tile_half, extent, wt;
      bit [31:0] hv;
      x    = item.x;
      y    = item.y;
      r    = (shadow_cfg.rate > pwb_pkg::WEIGHT_FULL) ? int'(pwb_pkg::WEIGHT_FULL)
                                                      : int'(shadow_cfg.rate);
      fw   = shadow_cfg.frame_width;
      fh   = shadow_cfg.frame_height;
      half = fw / 2;
      case (shadow_cfg.wipe_mode) inside
         pwb_pkg::MODE_SOFT_DOWN: begin
            boundary = (fh + pwb_pkg::SOFT_OFFSET) * (256 - r) / 256;
            wt = clamp_weight((y - boundary + pwb_pkg::SOFT_OFFSET) * 256
                              / pwb_pkg::SOFT_OFFSET);
         end
         pwb_pkg::MODE_SOFT_UP: begin
            boundary = (fh + pwb_pkg::SOFT_OFFSET) * r / 256;
            wt = clamp_weight((boundary - y) * 256 / pwb_pkg::SOFT_OFFSET);
         end
         pwb_pkg::MODE_SOFT_RIGHT: begin
            boundary = (fw + pwb_pkg::SOFT_OFFSET) * (256 - r) / 256;
            wt = clamp_weight((x - boundary + pwb_pkg::SOFT_OFFSET) * 256
                              / pwb_pkg::SOFT_OFFSET);
         end
         pwb_pkg::MODE_SOFT_LEFT: begin
            boundary = (fw + pwb_pkg::SOFT_OFFSET) * r / 256;
            wt = clamp_weight((boundary - x) * 256 / pwb_pkg::SOFT_OFFSET);
         end
         pwb_pkg::MODE_SPLIT_OPEN: begin
            boundary = (half + pwb_pkg::SPLIT_OFFSET) * (256 - r) / 256;
            wt = clamp_weight((half - magnitude(x - half) - boundary
                               + pwb_pkg::SPLIT_OFFSET) * 256 / pwb_pkg::SPLIT_OFFSET);
         end
         pwb_pkg::MODE_SPLIT_CLOSE: begin
            boundary = (half + pwb_pkg::SPLIT_OFFSET) * r / 256;
            wt = clamp_weight((magnitude(x - half) - half + boundary) * 256
                              / pwb_pkg::SPLIT_OFFSET);
         end
         pwb_pkg::MODE_DIAMOND_64, pwb_pkg::MODE_DIAMOND_32, pwb_pkg::MODE_DIAMOND_16: begin
            shift     = int'(shadow_cfg.wipe_mode) - int'(pwb_pkg::MODE_DIAMOND_64);
            tile_mask = int'(pwb_pkg::DIAMOND_MASK) >> shift;
            tile_half = int'(pwb_pkg::DIAMOND_HALF) >> shift;
            extent    = (int'(pwb_pkg::DIAMOND_SPAN) >> shift) * r / 256 - tile_half;
            if (magnitude((x & tile_mask) - tile_half)
                < magnitude((y & tile_mask) - tile_half) + extent) begin
               wt = int'(pwb_pkg::DIAMOND_FLOOR) + r * r / 512;
            end else begin
               wt = 0;
            end
         end
         pwb_pkg::MODE_DISSOLVE: begin
            hv = 32'(x) + 32'(y) * 32'(fw) + shadow_cfg.dissolve_seed * pwb_pkg::HASH_MUL_A;
            hv = hv ^ (hv >> 16);
            hv = hv * pwb_pkg::HASH_MUL_B;
            hv = hv ^ (hv >> 15);
            wt = (int'(hv[7:0]) < r) ? int'(pwb_pkg::WEIGHT_FULL) : 0;
         end
         default: begin
            wt = r;
         end
      endcase
      return wt[8:0];
   endfunction

   function automatic logic [7:0] mix_channel(int old_c, int new_c, int w);
      int mixed;
      mixed = (old_c * (256 - w) + new_c * w) / 256;
      return mixed[7:0];
   endfunction

   function automatic blend_type blend_pixel(pixel_item_type item);
      blend_type res;
      int        w;
      w          = wipe_weight(item);
      res.red    = mix_channel(item.pix.old_red, item.pix.new_red, w);
      res.green  = mix_channel(item.pix.old_green, item.pix.new_green, w);
      res.blue   = mix_channel(item.pix.old_blue, item.pix.new_blue, w);
      res.weight = w[8:0];
      return res;
   endfunction

   function automatic logic [7:0] random_channel();
      if ($urandom_range(0, 7) == 0) begin
         return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [COORD_WIDTH-1:0] random_coord(int size);
      int span;
      span = (size + 300 > 4095) ? 4095 : size + 300;
      if ($urandom_range(0, 3) == 0) begin
         return COORD_WIDTH'($urandom_range(0, 4095));
      end
      return COORD_WIDTH'($urandom_range(0, span));
   endfunction

   function automatic pixel_item_type random_pixel();
      pixel_item_type item;
      item.x             = random_coord(shadow_cfg.frame_width);
      item.y             = random_coord(shadow_cfg.frame_height);
      item.pix.old_red   = random_channel();
      item.pix.old_green = random_channel();
      item.pix.old_blue  = random_channel();
      item.pix.new_red   = random_channel();
      item.pix.new_green = random_channel();
      item.pix.new_blue  = random_channel();
      return item;
   endfunction

   task automatic compare_field(string label, int want, int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
      end
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pixel_queue.size() != 0 || req_bus.valid || blend_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [pwb_pkg::CSR_INDEX_WIDTH-1:0] index,
                            logic [31:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do begin
         @(posedge clock);
      end while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
      case (index)
         pwb_pkg::CSR_WIPE_MODE:     shadow_cfg.wipe_mode     = value[6:0];
         pwb_pkg::CSR_RATE:          shadow_cfg.rate          = value[8:0];
         pwb_pkg::CSR_FRAME_WIDTH:   shadow_cfg.frame_width   = value[11:0];
         pwb_pkg::CSR_FRAME_HEIGHT:  shadow_cfg.frame_height  = value[11:0];
         pwb_pkg::CSR_DISSOLVE_SEED: shadow_cfg.dissolve_seed = value;
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [6:0] mode, logic [8:0] rate, logic [11:0] fw,
                               logic [11:0] fh, logic [31:0] seed);
      wait_idle();
      write_reg(pwb_pkg::CSR_WIPE_MODE, 32'(mode));
      write_reg(pwb_pkg::CSR_RATE, 32'(rate));
      write_reg(pwb_pkg::CSR_FRAME_WIDTH, 32'(fw));
      write_reg(pwb_pkg::CSR_FRAME_HEIGHT, 32'(fh));
      write_reg(pwb_pkg::CSR_DISSOLVE_SEED, seed);
   endtask

   task automatic queue_corner_pair();
      pixel_item_type lo, hi;
      lo.x   = '0;
      lo.y   = '0;
      lo.pix = '{8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00};
      hi.x   = '1;
      hi.y   = '1;
      hi.pix = '{8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff};
      @(negedge clock);
      pixel_queue.push_back(lo);
      pixel_queue.push_back(hi);
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.pixel_x   <= '0;
         req_bus.pixel_y   <= '0;
         req_bus.old_red   <= '0;
         req_bus.old_green <= '0;
         req_bus.old_blue  <= '0;
         req_bus.new_red   <= '0;
         req_bus.new_green <= '0;
         req_bus.new_blue  <= '0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            blend_queue.push_back(blend_pixel(offered));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 || pixel_queue.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_bus.valid <= 1'b0;
            end else begin
               offered = pixel_queue.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.pixel_x   <= offered.x;
               req_bus.pixel_y   <= offered.y;
               req_bus.old_red   <= offered.pix.old_red;
               req_bus.old_green <= offered.pix.old_green;
               req_bus.old_blue  <= offered.pix.old_blue;
               req_bus.new_red   <= offered.pix.new_red;
               req_bus.new_green <= offered.pix.new_green;
               req_bus.new_blue  <= offered.pix.new_blue;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                               $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 4);
               end
            end
         end
      end
   end

   // long receiver hold-off, once, while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && result_count >= LONG_HOLD_AT && pixel_queue.size() > 16) begin
         hold_left <= LONG_HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // receiver: check each transfer, stall on a changing pattern
   always @(posedge clock) begin : response_check
      blend_type seen, want;
      bit        take;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.red    = rsp_bus.out_red;
            seen.green  = rsp_bus.out_green;
            seen.blue   = rsp_bus.out_blue;
            seen.weight = rsp_bus.mix_weight;
            result_count <= result_count + 1;
            if (blend_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result expected none actual %h", $time, seen);
            end else begin
               want = blend_queue.pop_front();
               compare_field("out_red", want.red, seen.red);
               compare_field("out_green", want.green, seen.green);
               compare_field("out_blue", want.blue, seen.blue);
               compare_field("mix_weight", want.weight, seen.weight);
            end
         end
         if (pattern_left == 0) begin
            ready_pattern = ready_pattern_type'($urandom_range(0, 3));
            pattern_left  = $urandom_range(8, 80);
         end else begin
            pattern_left--;
         end
         case (ready_pattern)
            READY_ALWAYS: take = 1'b1;
            READY_MOSTLY: take = ($urandom_range(0, 7) != 0);
            READY_HALF:   take = ($urandom_range(0, 1) != 0);
            default:      take = ($urandom_range(0, 4) == 0);
         endcase
         rsp_bus.ready <= take && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("procedural_wipe_blend_tb failed");
         $finish;
      end
   end

   initial begin
      int          random_total;
      int          count;
      logic [6:0]  mode;
      logic [8:0]  rate;
      logic [11:0] fw, fh;
      reset         = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      queue_corner_pair();
      apply_config(pwb_pkg::MODE_SOFT_DOWN, 9'd128, 12'd800, 12'd600, 32'd0);
      queue_corner_pair();
      // rate above range saturates
      apply_config(pwb_pkg::MODE_SOFT_UP, 9'd511, 12'd800, 12'd600, 32'd0);
      queue_corner_pair();
      // zero frame size shifts the wipe edge
      apply_config(pwb_pkg::MODE_SOFT_RIGHT, 9'd0, 12'd0, 12'd0, 32'd0);
      queue_corner_pair();
      apply_config(pwb_pkg::MODE_SOFT_LEFT, 9'd256, 12'd4095, 12'd4095, 32'd0);
      queue_corner_pair();
      apply_config(pwb_pkg::MODE_SPLIT_OPEN, 9'd64, 12'd1, 12'd1, 32'd0);
      queue_corner_pair();
      apply_config(pwb_pkg::MODE_SPLIT_CLOSE, 9'd200, 12'd801, 12'd3, 32'd0);
      queue_corner_pair();
      apply_config(pwb_pkg::MODE_DIAMOND_64, 9'd256, 12'd640, 12'd480, 32'd0);
      queue_corner_pair();
      apply_config(pwb_pkg::MODE_DIAMOND_32, 9'd128, 12'd640, 12'd480, 32'd0);
      queue_corner_pair();
      apply_config(pwb_pkg::MODE_DIAMOND_16, 9'd0, 12'd640, 12'd480, 32'd0);
      queue_corner_pair();
      apply_config(pwb_pkg::MODE_DISSOLVE, 9'd100, 12'd800, 12'd600, 32'hffff_ffff);
      queue_corner_pair();
      apply_config(MODE_FADE_TOP, 9'd300, 12'd800, 12'd600, 32'd0);
      queue_corner_pair();

      random_total = 0;
      while (random_total < RANDOM_ITEMS) begin
         mode = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                            : WIPE_MODES[$urandom_range(0, 9)];
         case ($urandom_range(0, 7))
            0:       rate = 9'd0;
            1:       rate = pwb_pkg::WEIGHT_FULL;
            2:       rate = 9'($urandom_range(257, 511));
            default: rate = 9'($urandom_range(0, 256));
         endcase
         case ($urandom_range(0, 7))
            0:       fw = 12'($urandom_range(0, 3));
            1:       fw = 12'd4095;
            2:       fw = 12'($urandom_range(0, 4095));
            default: fw = 12'($urandom_range(16, 1023));
         endcase
         case ($urandom_range(0, 7))
            0:       fh = 12'($urandom_range(0, 3));
            1:       fh = 12'd4095;
            2:       fh = 12'($urandom_range(0, 4095));
            default: fh = 12'($urandom_range(16, 1023));
         endcase
         apply_config(mode, rate, fw, fh, $urandom());
         count = $urandom_range(30, 120);
         @(negedge clock);
         repeat (count) pixel_queue.push_back(random_pixel());
         random_total += count;
      end

      wait_idle();
      if (error_count == 0) begin
         $display("procedural_wipe_blend_tb passed");
      end else begin
         $display("procedural_wipe_blend_tb failed");
      end
      $finish;
   end

endmodule
